[src/aer_pkg.sv]
// ----------------------------------------------------------------------------
// aer_pkg: shared types, constants and functions for the AES round block.
// Holds the byte-array state type, the pipeline payload, the round codes,
// the S-box and the GF(2^8) doubling used by MixColumns.
// ----------------------------------------------------------------------------
package aer_pkg;

	// Byte 0 is the most significant byte, matching {hi, lo} word packing.
	typedef logic [0:15][7:0] state_t;

	typedef struct packed {
		logic [1:0] func;
		state_t     state;
		state_t     key;
	} pipe_t;

	localparam logic [1:0] FUNC_ADD_KEY = 2'd0;
	localparam logic [1:0] FUNC_FULL    = 2'd1;
	localparam logic [1:0] FUNC_FINAL   = 2'd2;

	localparam logic [7:0] GF_REDUCE = 8'h1b;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] v);
		logic [7:0] d;
		d = {v[6:0], 1'b0};
		return v[7] ? (d ^ GF_REDUCE) : d;
	endfunction

endpackage

[src/aes_encrypt_round.sv]
// ----------------------------------------------------------------------------
// aes_encrypt_round: one AES encryption round on a 128-bit state.
// An input transfer on in_valid/in_ready carries func, the state and the
// round key; an output transfer on out_valid/out_ready returns the new state.
// func 1 is a full round, 2 the final round without MixColumns, and 0 or 3
// AddRoundKey alone. An accepted item is registered in turn by the three
// stages, an input register, the S-box stage and the MixColumns/AddRoundKey
// stage, which is also the output register, and out_valid then rises. One
// item is accepted every cycle while the receiver does not stall.
// Each stage has its own valid bit and advances when it is empty or the stage
// after it advances, so when the receiver stalls, bubbles still fill and
// in_ready drops only once all three stages hold items; nothing is lost or
// repeated. Reset clears the valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module aes_encrypt_round
	import aer_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] state_hi,
	input  logic [63:0] state_lo,
	input  logic [63:0] key_hi,
	input  logic [63:0] key_lo,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo
);

	logic   v_s1, v_s2, v_s3;
	logic   en_s1, en_s2, en_s3;
	pipe_t  in_item;
	pipe_t  item_s1;
	pipe_t  item_s2;
	state_t res_s3;

	// A stage may load when it is empty or its contents move on this cycle.
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	assign in_item = '{func: func, state: {state_hi, state_lo}, key: {key_hi, key_lo}};

	// Input register: payload only, loaded on each input transfer.
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	aer_sub_shift u_sub_shift (
		.clk  (clk),
		.load (en_s2 && v_s1),
		.d    (item_s1),
		.q    (item_s2)
	);

	aer_mix_key u_mix_key (
		.clk  (clk),
		.load (en_s3 && v_s2),
		.d    (item_s2),
		.q    (res_s3)
	);

	assign out_valid = v_s3;
	assign out_hi    = res_s3[0:7];
	assign out_lo    = res_s3[8:15];

`ifndef SYNTHESIS
	// With the first stage empty, the block must take a new item.
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("in_ready low with an empty input stage");

	// An item waiting in the middle stage is kept while the output is blocked.
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en_s3 |=> v_s2)
		else $error("middle stage item dropped during a stall");

	// A result only appears if it was already there or came from stage two.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result appeared without a stage two item");
`endif

endmodule

[src/aer_sub_shift.sv]
// ----------------------------------------------------------------------------
// aer_sub_shift: SubBytes and ShiftRows stage.
// Substitutes every byte through the S-box and rotates row r left by r
// columns for the two cipher rounds; add-key-only items pass unchanged.
// ----------------------------------------------------------------------------
module aer_sub_shift
	import aer_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  pipe_t d,
	output pipe_t q
);

	state_t sub_shift;
	pipe_t  nxt;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				sub_shift[r * 4 + c] = SBOX[d.state[r * 4 + ((c + r) % 4)]];
			end
		end
	end

	always_comb begin
		nxt = d;
		unique case (d.func)
			FUNC_FULL, FUNC_FINAL: nxt.state = sub_shift;
			default:               nxt.state = d.state;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q <= nxt;
		end
	end

endmodule

[src/aer_mix_key.sv]
// ----------------------------------------------------------------------------
// aer_mix_key: MixColumns and AddRoundKey stage.
// Mixes each column for full rounds, then adds the round key and registers
// the new state as the block's result.
// ----------------------------------------------------------------------------
module aer_mix_key
	import aer_pkg::*;
(
	input  logic   clk,
	input  logic   load,
	input  pipe_t  d,
	output state_t q
);

	state_t mixed;
	state_t sel;

	always_comb begin
		for (int c = 0; c < 4; c++) begin : g_col
			logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
			a0 = d.state[c];
			a1 = d.state[c + 4];
			a2 = d.state[c + 8];
			a3 = d.state[c + 12];
			d0 = xtime(a0);
			d1 = xtime(a1);
			d2 = xtime(a2);
			d3 = xtime(a3);
			mixed[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			mixed[c + 4]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			mixed[c + 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			mixed[c + 12] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
	end

	always_comb begin
		unique case (d.func)
			FUNC_FULL: sel = mixed;
			default:   sel = d.state;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			q <= sel ^ d.key;
		end
	end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for aes_encrypt_round.
// Rounds of every type are sent through the valid/ready input while the
// output side stalls at random. Each input transfer is predicted by an
// independent round model whose S-box is derived from the GF(2^8) inverse
// and affine map. Each output transfer is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;
	import aer_pkg::*;

	// The block treats the spare round code like AddRoundKey alone.
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam int RANDOM_ROUNDS  = 1950;
	localparam int MAX_WAIT       = 17;
	localparam int HOLD_AFTER     = 500;
	localparam int HOLD_CYCLES    = 160;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct {
		logic [1:0]  op;
		logic [63:0] s_hi;
		logic [63:0] s_lo;
		logic [63:0] k_hi;
		logic [63:0] k_lo;
	} round_req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  func      = FUNC_ADD_KEY;
	logic [63:0] state_hi  = '0;
	logic [63:0] state_lo  = '0;
	logic [63:0] key_hi    = '0;
	logic [63:0] key_lo    = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] out_hi;
	logic [63:0] out_lo;

	round_req_t  pending_rounds[$];
	state_t      expected_states[$];
	logic [7:0]  sbox_tab [256];

	// Transfer flags seen at the last rising edge, read by the drivers at
	// the falling edge that follows.
	logic in_took  = 1'b0;
	logic out_took = 1'b0;

	int rounds_total  = 0;
	int rounds_sent   = 0;
	int mismatches    = 0;
	int idle_cycles   = 0;

	aes_encrypt_round dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.state_hi (state_hi),
		.state_lo (state_lo),
		.key_hi   (key_hi),
		.key_lo   (key_lo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_hi   (out_hi),
		.out_lo   (out_lo)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Round model
	// ------------------------------------------------------------------

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = '0;
		sh  = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= sh;
			sh = gf_double(sh);
		end
		return acc;
	endfunction

	// The substitution table is rebuilt from its definition: the inverse in
	// GF(2^8), with zero mapped to zero, followed by the affine map.
	task automatic build_sbox();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			for (int y = 1; y < 256; y++)
				if (x != 0 && gf_mul(8'(x), 8'(y)) == 8'h01)
					inv = 8'(y);
			sbox_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
			            ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	endtask

	// Byte k of a state sits at row k/4 and column k%4.
	function automatic state_t aes_round_predict(input logic [1:0] op, input state_t st,
	                                             input state_t rk);
		state_t     t;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		t = st;
		if (op == FUNC_FULL || op == FUNC_FINAL) begin
			// SubBytes and ShiftRows: row r rotates left by r places.
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					t[r * 4 + c] = sbox_tab[st[r * 4 + ((c + r) % 4)]];
			st = t;
			if (op == FUNC_FULL) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[c];
					a1 = st[c + 4];
					a2 = st[c + 8];
					a3 = st[c + 12];
					d0 = gf_double(a0);
					d1 = gf_double(a1);
					d2 = gf_double(a2);
					d3 = gf_double(a3);
					t[c]      = d0 ^ d1 ^ a1 ^ a2 ^ a3;
					t[c + 4]  = a0 ^ d1 ^ d2 ^ a2 ^ a3;
					t[c + 8]  = a0 ^ a1 ^ d2 ^ d3 ^ a3;
					t[c + 12] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
				end
			end
		end
		return t ^ rk;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic add_round(input logic [1:0] op, input logic [63:0] s_hi,
	                         input logic [63:0] s_lo, input logic [63:0] k_hi,
	                         input logic [63:0] k_lo);
		round_req_t req;
		req.op   = op;
		req.s_hi = s_hi;
		req.s_lo = s_lo;
		req.k_hi = k_hi;
		req.k_lo = k_lo;
		pending_rounds.insert(pending_rounds.size(), req);
		rounds_total++;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic int draw_wait(input logic quiet);
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	initial begin
		logic [1:0] op;
		build_sbox();

		// Every round type with all-zero and all-one state and key.
		for (int f = 0; f < 4; f++) begin
			add_round(2'(f), '0, '0, '0, '0);
			add_round(2'(f), '1, '1, '1, '1);
		end
		// Distinct bytes make the row rotation visible; the zero key leaves
		// the raw transform on the output.
		add_round(FUNC_FINAL, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
		add_round(FUNC_FULL,  64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
		// Bytes with the top bit set drive the reduction in MixColumns.
		add_round(FUNC_FULL,  64'h8080808080808080, 64'h8080808080808080,
		          64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
		add_round(FUNC_FULL,  64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, '1, '0);
		add_round(FUNC_ADD_KEY, '1, '0, '0, '1);
		add_round(FUNC_SPARE, 64'h0123456789abcdef, 64'hfedcba9876543210,
		          64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0);
		add_round(FUNC_FINAL, 64'hff00ff00ff00ff00, 64'h00ff00ff00ff00ff, '0, '1);
		add_round(FUNC_SPARE, rand_word(), rand_word(), rand_word(), rand_word());

		// Random rounds; one in eight has a zero key.
		for (int i = 0; i < RANDOM_ROUNDS; i++) begin
			op = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0)
				add_round(op, rand_word(), rand_word(), '0, '0);
			else
				add_round(op, rand_word(), rand_word(), rand_word(), rand_word());
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Counters are updated at the rising edge and read here at the
		// falling edge, so there is no race with the monitor.
		do
			@(negedge clk);
		while (rounds_sent != rounds_total || expected_states.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0)
			$display("aes_encrypt_round test passed");
		else
			$display("aes_encrypt_round test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Input driver: offers pending rounds with a random gap before each.
	// ------------------------------------------------------------------

	int   tx_gap   = 0;
	int   tx_run   = 0;
	logic tx_quiet = 1'b0;

	always @(negedge clk) begin : round_driver
		round_req_t req;
		logic       offer;
		// A round still waiting for its transfer stays on the bus.
		offer = in_valid && !in_took;
		if (arst_n && !offer) begin
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending_rounds.size() != 0) begin
				req = pending_rounds.pop_front();
				func     <= req.op;
				state_hi <= req.s_hi;
				state_lo <= req.s_lo;
				key_hi   <= req.k_hi;
				key_lo   <= req.k_lo;
				offer = 1'b1;
				// Stretches without gaps alternate with randomly gapped ones.
				if (tx_run == 0) begin
					tx_run   = $urandom_range(20, 80);
					tx_quiet = ($urandom_range(0, 3) == 0);
				end
				tx_run--;
				tx_gap = draw_wait(tx_quiet);
			end
		end
		in_valid <= offer;
	end

	// ------------------------------------------------------------------
	// Output side: may stall at random after each transfer, and once holds off
	// for a long stretch so the pipeline fills and in_ready drops.
	// ------------------------------------------------------------------

	int   rx_stall = 0;
	int   rx_run   = 0;
	int   rx_count = 0;
	logic rx_quiet = 1'b0;
	logic rx_held  = 1'b0;

	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (out_took) begin
				rx_count++;
				if (rx_run == 0) begin
					rx_run   = $urandom_range(20, 80);
					rx_quiet = ($urandom_range(0, 3) == 0);
				end
				rx_run--;
				rx_stall = draw_wait(rx_quiet);
				if (!rx_held && rx_count == HOLD_AFTER) begin
					rx_stall = HOLD_CYCLES;
					rx_held  = 1'b1;
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each input transfer, checks each output one.
	// ------------------------------------------------------------------

	always @(posedge clk) begin : round_monitor
		logic [127:0] want;
		logic         in_fire;
		logic         out_fire;
		in_fire  = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		in_took  <= in_fire;
		out_took <= out_fire;

		if (in_fire) begin
			expected_states.insert(expected_states.size(),
			                       aes_round_predict(func, {state_hi, state_lo},
			                                         {key_hi, key_lo}));
			rounds_sent++;
		end

		if (out_fire) begin
			if (expected_states.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h %h",
				         $time, out_hi, out_lo);
				mismatches++;
			end else begin
				want = expected_states.pop_front();
				if (out_hi !== want[127:64]) begin
					$display("%0t: out_hi mismatch, expected %h, got %h",
					         $time, want[127:64], out_hi);
					mismatches++;
				end
				if (out_lo !== want[63:0]) begin
					$display("%0t: out_lo mismatch, expected %h, got %h",
					         $time, want[63:0], out_lo);
					mismatches++;
				end
			end
		end

		// A run that stops moving in both directions has hung.
		if (!arst_n || in_fire || out_fire)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("aes_encrypt_round test failed");
			$finish;
		end
	end

endmodule

[files.f]
src/aer_pkg.sv
src/aer_sub_shift.sv
src/aer_mix_key.sv
src/aes_encrypt_round.sv
tb/sv/tb.sv
